// ===== rtl/edge_normalized_box_filter_3x3_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 edge-normalized box filter.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef EDGE_NORMALIZED_BOX_FILTER_3X3_CORE_DEFINES_SVH
`define EDGE_NORMALIZED_BOX_FILTER_3X3_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ENBF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ENBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/enbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// enbf_pkg
// Shared widths, register map and divider constants of the box filter.
// ---------------------------------------------------------------------------
package enbf_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int SIZE_W   = 11;
    localparam int TOL_W    = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Sum of up to nine samples plus the rounding term.
    localparam int SUM_W    = SAMPLE_W + 4;

    // Register selects (paddr bit 2) and reset values.
    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_TOL  = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd655;

    // Divisor codes for the clipped neighborhood.
    localparam logic [1:0] DIV4 = 2'd0;
    localparam logic [1:0] DIV6 = 2'd1;
    localparam logic [1:0] DIV9 = 2'd2;

    // Reciprocals scaled by 2^RECIP_SHIFT; exact for every sum in range.
    // Division by six halves the sum first and then divides by three.
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP4 = 22'd2097152;
    localparam logic [RECIP_W-1:0] RECIP3 = 22'd2796203;
    localparam logic [RECIP_W-1:0] RECIP9 = 22'd932068;

endpackage
`default_nettype wire

// ===== rtl/enbf_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// enbf_line_buf
// Line buffer holding the two previous rows, one word per column, with a
// registered read port and a separate write port.
// ---------------------------------------------------------------------------
module enbf_line_buf
    import enbf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [2*SAMPLE_W-1:0]      rd_data,   // [15:0] previous row, [31:16] row before
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [2*SAMPLE_W-1:0]      wr_data
);

    logic [2*SAMPLE_W-1:0] line_mem_reg [DEPTH];
    logic [2*SAMPLE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/edge_normalized_box_filter_3x3_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "edge_normalized_box_filter_3x3_core_defines.svh"
// ---------------------------------------------------------------------------
// edge_normalized_box_filter_3x3_core
// Smoothing pass over a square matrix of Q0.16 samples streamed in raster
// order; each result is the rounded mean of its border-clipped 3x3 window.
//
// Usage:
//   Samples enter on the s_axis channel, one transaction per element, rows in
//   order. Results leave on the m_axis channel in raster order, lagging the
//   input stream by one row plus one element, so the last row of a matrix is
//   delivered while the next matrix is being fed. tlast marks the final
//   element of a matrix; tuser then says whether every result of that matrix
//   lay within the tolerance of its first result.
//   Throughput is one sample per cycle while the receiver keeps up. A
//   result reaches m_axis through the input register, sum register and
//   result register after the transaction that completes its window; the
//   line buffer read is registered. When the receiver stalls, the pipeline
//   keeps accepting until its three stages are full, then s_axis_tready drops.
//   Reset loads size 512 and tolerance 655 and restarts the stream. Writing
//   size_in_use over APB also restarts the stream and drops any unfinished
//   matrix. Configure only while the block is idle. The line buffers are not
//   cleared; the first row pair of a stream overwrites them before use.
// ---------------------------------------------------------------------------
module edge_normalized_box_filter_3x3_core
    import enbf_pkg::*;
#(
    parameter int MAX_SIZE = 1024
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
    // Output stream.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SAMPLE_W-1:0]         m_axis_tdata,   // [15:0] smoothed
    output logic                        m_axis_tlast,   // end_of_matrix
    output logic                        m_axis_tuser,   // [0] converged
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic      [APB_DW-1:0]      prdata,
    output logic                        pready
);

    localparam int IDX_W = $clog2(MAX_SIZE);
    localparam int CMP_W = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
    localparam int PROD_W = SUM_W + RECIP_W;

    // Window position flags of the result an element completes.
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
        logic first;
        logic last;
    } win_flags_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    col;
        win_flags_t          flags;
    } in_stage_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [1:0]       div;
        logic             first;
        logic             last;
    } sum_stage_t;

    // Configuration registers.
    logic [SIZE_W-1:0]  size_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic               cfg_wr;
    logic               restart;

    // Stream position.
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;
    logic               priming_reg;
    logic [IDX_W-1:0]   n_last;
    logic [CMP_W-1:0]   size_ext;

    // Pipeline.
    logic               s1_valid_reg;
    in_stage_t          s1_reg;
    win_flags_t         flags_next;
    logic               s2_valid_reg;
    sum_stage_t         s2_reg;
    sum_stage_t         s2_next;
    logic               out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic               out_last_reg;
    logic               out_conv_reg;

    // Window: the two newest columns, rows top to bottom.
    logic [SAMPLE_W-1:0] w1_reg [3];
    logic [SAMPLE_W-1:0] w2_reg [3];
    logic [SAMPLE_W-1:0] new_col [3];

    // Convergence tracking.
    logic [SAMPLE_W-1:0] first_reg;
    logic                all_within_reg;

    // Handshake.
    logic               accept;
    logic               s1_adv;
    logic               s2_free;
    logic               s2_adv;

    // Line buffer.
    logic [2*SAMPLE_W-1:0] lb_rd_data;

    // Result stage.
    logic [SUM_W-1:0]    mul_a;
    logic [RECIP_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] first_next;
    logic [SAMPLE_W-1:0] diff;
    logic                within_next;

    // ------------------------------------------------------------------
    // APB configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && (paddr[2] == REG_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            tol_reg  <= TOL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SIZE)
            begin
                size_reg <= pwdata[SIZE_W-1:0];
            end
            else
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_SIZE)
        begin
            prdata = APB_DW'(size_reg);
        end
        else
        begin
            prdata = APB_DW'(tol_reg);
        end
    end

    // Matrix dimension minus one, with out-of-range sizes clamped.
    always_comb
    begin
        size_ext = CMP_W'(size_reg);
        if (size_ext < CMP_W'(2))
        begin
            n_last = IDX_W'(1);
        end
        else if (size_ext > CMP_W'(MAX_SIZE))
        begin
            n_last = IDX_W'(MAX_SIZE - 1);
        end
        else
        begin
            n_last = IDX_W'(size_ext - CMP_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage loads when empty or when it moves on.
    // ------------------------------------------------------------------
    assign s2_adv        = !out_valid_reg || m_axis_tready;
    assign s2_free       = !s2_valid_reg || s2_adv;
    assign s1_adv        = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s2_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Which result, if any, the incoming element completes.
    // At column zero the last element of an earlier row finishes; elsewhere
    // the element one row up and one column left finishes.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic             active;
        logic             c_zero;
        logic [IDX_W-1:0] orow;

        c_zero = (col_reg == '0);
        active = !priming_reg || (row_reg > IDX_W'(1)) ||
                 ((row_reg == IDX_W'(1)) && !c_zero);
        if (c_zero)
        begin
            if (row_reg > IDX_W'(1))
            begin
                orow = row_reg - IDX_W'(1) - IDX_W'(1);
            end
            else
            begin
                orow = row_reg + n_last - IDX_W'(1);
            end
        end
        else
        begin
            if (row_reg == '0)
            begin
                orow = n_last;
            end
            else
            begin
                orow = row_reg - IDX_W'(1);
            end
        end

        flags_next.emit      = active;
        flags_next.top_ok    = (orow != '0);
        flags_next.bottom_ok = (orow != n_last);
        flags_next.left_ok   = c_zero || (col_reg > IDX_W'(1));
        flags_next.right_ok  = !c_zero;
        flags_next.first     = (col_reg == IDX_W'(1)) && (orow == '0);
        flags_next.last      = c_zero && (orow == n_last);
    end

    // Stream position and input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            priming_reg  <= 1'b1;
            s1_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            priming_reg <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (col_reg == n_last)
                begin
                    col_reg <= '0;
                    if (row_reg == n_last)
                    begin
                        row_reg     <= '0;
                        priming_reg <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= row_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + IDX_W'(1);
                end
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.sample <= s_axis_tdata;
            s1_reg.col    <= col_reg;
            s1_reg.flags  <= flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: read at acceptance, updated when the element moves on.
    // ------------------------------------------------------------------
    enbf_line_buf #(
        .DEPTH   (MAX_SIZE)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.col),
        .wr_data ({lb_rd_data[SAMPLE_W-1:0], s1_reg.sample})
    );

    assign new_col[0] = lb_rd_data[2*SAMPLE_W-1:SAMPLE_W];
    assign new_col[1] = lb_rd_data[SAMPLE_W-1:0];
    assign new_col[2] = s1_reg.sample;

    // Window shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w1_reg[k] <= '0;
                w2_reg[k] <= '0;
            end
        end
        else if (restart)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w1_reg[k] <= '0;
                w2_reg[k] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w1_reg[k] <= w2_reg[k];
                w2_reg[k] <= new_col[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Clipped window sum plus half the divisor for rounding.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic row_on;
        logic all_cols;
        logic all_rows;

        s2_next.sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            row_on = (k == 1) || ((k == 0) && s1_reg.flags.top_ok) ||
                     ((k == 2) && s1_reg.flags.bottom_ok);
            if (row_on)
            begin
                if (s1_reg.flags.left_ok)
                begin
                    s2_next.sum = s2_next.sum + SUM_W'(w1_reg[k]);
                end
                s2_next.sum = s2_next.sum + SUM_W'(w2_reg[k]);
                if (s1_reg.flags.right_ok)
                begin
                    s2_next.sum = s2_next.sum + SUM_W'(new_col[k]);
                end
            end
        end

        all_cols = s1_reg.flags.left_ok && s1_reg.flags.right_ok;
        all_rows = s1_reg.flags.top_ok && s1_reg.flags.bottom_ok;
        if (all_cols && all_rows)
        begin
            s2_next.div = DIV9;
            s2_next.sum = s2_next.sum + SUM_W'(4);
        end
        else if (all_cols || all_rows)
        begin
            s2_next.div = DIV6;
            s2_next.sum = s2_next.sum + SUM_W'(3);
        end
        else
        begin
            s2_next.div = DIV4;
            s2_next.sum = s2_next.sum + SUM_W'(2);
        end
        s2_next.first = s1_reg.flags.first;
        s2_next.last  = s1_reg.flags.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_reg.flags.emit;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Division by reciprocal multiplication and the tolerance check.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (s2_reg.div)
            DIV9:
            begin
                mul_a = s2_reg.sum;
                mul_b = RECIP9;
            end
            DIV6:
            begin
                mul_a = s2_reg.sum >> 1;
                mul_b = RECIP3;
            end
            default:
            begin
                mul_a = s2_reg.sum;
                mul_b = RECIP4;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        mean = prod[RECIP_SHIFT +: SAMPLE_W];

        first_next = s2_reg.first ? mean : first_reg;
        if (mean >= first_next)
        begin
            diff = mean - first_next;
        end
        else
        begin
            diff = first_next - mean;
        end
        within_next = all_within_reg && (TOL_W'(diff) < tol_reg);
    end

    // Result register and convergence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            first_reg      <= '0;
            all_within_reg <= 1'b1;
        end
        else
        begin
            if (s2_valid_reg && s2_adv)
            begin
                out_valid_reg  <= 1'b1;
                first_reg      <= first_next;
                all_within_reg <= s2_reg.last ? 1'b1 : within_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (restart)
            begin
                all_within_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_adv)
        begin
            out_data_reg <= mean;
            out_last_reg <= s2_reg.last;
            out_conv_reg <= s2_reg.last && within_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_conv_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ENBF_ASSERT_IMPLIES(a_s1_no_overrun, accept && s1_valid_reg, s1_adv,
        "input register overwritten before its element moved on")
    `ENBF_ASSERT_IMPLIES(a_s2_no_overrun, s1_adv && s1_reg.flags.emit && s2_valid_reg, s2_adv,
        "sum register overwritten before its result moved on")
    `ENBF_ASSERT_IMPLIES(a_pos_range, 1'b1, (col_reg <= n_last) && (row_reg <= n_last),
        "stream position outside the matrix")
    `ENBF_ASSERT_NEXT(a_restart, restart,
        (col_reg == '0) && (row_reg == '0) && priming_reg && all_within_reg,
        "size write did not restart the stream")
    `ENBF_ASSERT_IMPLIES(a_conv_at_end, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
        "converged flag raised away from the end of a matrix")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for edge_normalized_box_filter_3x3_core
// Streams square matrices of Q0.16 samples through the filter under random
// back-pressure and source gaps, predicts every border-clipped 3x3 mean and
// convergence flag in a scoreboard class, and checks each result in order.
// Register writes are verified by read-back over the APB port.
// ----------------------------------------------------------------------------
module testbench;
    import enbf_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int SETTLE       = 16;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 130;

    localparam logic [APB_AW-1:0] ADDR_SIZE = {REG_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_TOL  = {REG_TOL, 2'b00};

    // Sample patterns used by the stimulus.
    typedef enum int {PAT_RANDOM, PAT_SMOOTH, PAT_EXTREME} pattern_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic                last;
        logic                conv;
    } mean_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the filter state and holds the expected means.
    // ------------------------------------------------------------------------
    class smooth_tracker;
        mean_t               pending_means[$];
        logic [SIZE_W-1:0]   size_reg;
        logic [TOL_W-1:0]    tol_reg;
        logic [SAMPLE_W-1:0] prev_line[MAX_DIM];
        logic [SAMPLE_W-1:0] older_line[MAX_DIM];
        logic [SAMPLE_W-1:0] win[3][3];   // [column: 0 oldest][row: 0 top]
        int unsigned         row;
        int unsigned         col;
        logic [SAMPLE_W-1:0] first_mean;
        bit                  all_close;
        bit                  priming;
        int                  mismatches;
        int                  checked;
        int                  samples;
        int                  matrices;
        int                  converged_seen;

        function new();
            size_reg       = SIZE_RESET;
            tol_reg        = TOL_RESET;
            first_mean     = '0;
            mismatches     = 0;
            checked        = 0;
            samples        = 0;
            matrices       = 0;
            converged_seen = 0;
            for (int i = 0; i < MAX_DIM; i++)
            begin
                prev_line[i]  = '0;
                older_line[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            row       = 0;
            col       = 0;
            all_close = 1'b1;
            priming   = 1'b1;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
        endfunction

        function int unsigned dim();
            if (size_reg < 2)
                return 2;
            if (size_reg > MAX_DIM)
                return MAX_DIM;
            return size_reg;
        endfunction

        // A size write restarts the stream; a tolerance write does not.
        function void write_register(bit is_tol, logic [APB_DW-1:0] value);
            if (is_tol)
                tol_reg = value[TOL_W-1:0];
            else
            begin
                size_reg = value[SIZE_W-1:0];
                restart();
            end
        endfunction

        // Rounded mean over window columns lo..2, rows clipped at the border.
        function logic [SAMPLE_W-1:0] window_mean(int lo, bit top_ok, bit bot_ok);
            int unsigned sum;
            int unsigned cnt;
            sum = 0;
            for (int k = lo; k <= 2; k++)
            begin
                if (top_ok)
                    sum += win[k][0];
                sum += win[k][1];
                if (bot_ok)
                    sum += win[k][2];
            end
            cnt = (3 - lo) * (1 + top_ok + bot_ok);
            return SAMPLE_W'((sum + cnt / 2) / cnt);
        endfunction

        function void predict(int unsigned orow, int unsigned ocol, int lo);
            int unsigned         n;
            logic [SAMPLE_W-1:0] v;
            logic [SAMPLE_W-1:0] diff;
            mean_t               item;
            n = dim();
            v = window_mean(lo, orow != 0, orow != n - 1);
            if (orow == 0 && ocol == 0)
                first_mean = v;
            diff = (v >= first_mean) ? v - first_mean : first_mean - v;
            if (!(diff < tol_reg))
                all_close = 1'b0;
            item.mean = v;
            item.last = (orow == n - 1) && (ocol == n - 1);
            item.conv = item.last && all_close;
            if (item.last)
                all_close = 1'b1;
            pending_means.push_back(item);
        endfunction

        // Notes one accepted sample and queues the result it completes.
        function void take_sample(logic [SAMPLE_W-1:0] s);
            int unsigned n;
            bit          active;
            n = dim();
            samples++;
            if (row >= n || col >= n)
            begin
                row = 0;
                col = 0;
            end
            active = !priming || row >= 2 || (row == 1 && col >= 1);

            // Column zero finishes the last element of the row two back.
            if (col == 0 && active)
                predict((row >= 2) ? row - 2 : row + n - 2, n - 1, 1);

            for (int k = 0; k < 3; k++)
            begin
                win[0][k] = win[1][k];
                win[1][k] = win[2][k];
            end
            win[2][0]       = older_line[col];
            win[2][1]       = prev_line[col];
            win[2][2]       = s;
            older_line[col] = prev_line[col];
            prev_line[col]  = s;

            if (col >= 1 && active)
                predict((row >= 1) ? row - 1 : n - 1, col - 1, (col >= 2) ? 0 : 1);

            col++;
            if (col >= n)
            begin
                col = 0;
                row++;
                if (row >= n)
                begin
                    row     = 0;
                    priming = 1'b0;
                end
            end
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void compare(string what, int unsigned want, int unsigned got);
            if (want != got)
                note_failure($sformatf("%s: expected %h, got %h", what, want, got));
        endfunction

        // Checks one accepted result against the oldest expectation.
        function void check_smoothed(logic [SAMPLE_W-1:0] mean, logic last, logic conv);
            mean_t want;
            if (pending_means.size() == 0)
            begin
                note_failure($sformatf("unexpected result %h (last %b, converged %b)",
                                       mean, last, conv));
                return;
            end
            want = pending_means.pop_front();
            checked++;
            compare($sformatf("result %0d smoothed", checked), want.mean, mean);
            compare($sformatf("result %0d end_of_matrix", checked), want.last, last);
            compare($sformatf("result %0d converged", checked), want.conv, conv);
            if (last === 1'b1)
                matrices++;
            if (conv === 1'b1)
                converged_seen++;
        endfunction

        function int outstanding();
            return pending_means.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the device under test.
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SAMPLE_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    smooth_tracker tracker;
    bit            quiet;
    bit            sender_calm;
    int            phase_count;

    edge_normalized_box_filter_3x3_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time.
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver back-pressure: ready runs broken by stall bursts.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // Every accepted output transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_smoothed(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------
    function automatic int source_gap();
        if (quiet || sender_calm || $urandom_range(0, 99) >= 20)
            return 0;
        return $urandom_range(1, 14);
    endfunction

    function automatic int unsigned effective_dim(int unsigned size_value);
        if (size_value < 2)
            return 2;
        if (size_value > MAX_DIM)
            return MAX_DIM;
        return size_value;
    endfunction

    function automatic logic [SAMPLE_W-1:0] make_sample(pattern_t pat, int unsigned base,
                                                        int unsigned spread);
        int unsigned v;
        case (pat)
            PAT_SMOOTH:
            begin
                v = base + $urandom_range(0, spread);
                return (v > 65535) ? 16'hFFFF : SAMPLE_W'(v);
            end
            PAT_EXTREME:
                return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:
                return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_sample(value);
    endtask

    // Stops the source and waits until every expected result has arrived.
    task automatic drain_results(input bit settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] readback;
        mask    = (addr == ADDR_TOL) ? 32'h0000_FFFF : 32'h0000_07FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_register(addr == ADDR_TOL, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        tracker.compare($sformatf("register read at %h", addr), value & mask, readback);
    endtask

    // One phase: idle the block, set the tolerance and, unless kept, the size, then stream samples.
    task automatic run_phase(input int unsigned size_value, input int unsigned tol_value,
                             input int items, input pattern_t pat, input bit keep_size,
                             input bit hold_mid);
        int unsigned base;
        int unsigned spread;
        drain_results(1'b1);
        if (!keep_size)
            write_reg(ADDR_SIZE, ($urandom & 32'hFFFF_F800) | (size_value & 32'h7FF));
        write_reg(ADDR_TOL, ($urandom & 32'hFFFF_0000) | (tol_value & 32'hFFFF));
        sender_calm = ($urandom_range(0, 3) == 0);
        base        = $urandom_range(0, 65535);
        spread      = $urandom_range(0, 600);
        phase_count++;
        for (int i = 0; i < items; i++)
        begin
            if (hold_mid && i == items / 2)
                drain_results(1'b0);
            send_sample(make_sample(pat, base, spread));
        end
    endtask

    task automatic send_list(input logic [SAMPLE_W-1:0] values[$]);
        foreach (values[i])
            send_sample(values[i]);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int          random_items;
        int unsigned size_value;
        int unsigned tol_value;
        int unsigned n;
        int          items;
        int          pick;
        bit          keep;

        tracker       = new();
        quiet         = 1'b0;
        sender_calm   = 1'b0;
        phase_count   = 0;
        random_items  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: size below range acts as two, zero tolerance, full-scale samples.
        write_reg(ADDR_SIZE, 32'd0);
        write_reg(ADDR_TOL, 32'd0);
        phase_count++;
        send_list('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});

        // Directed: 3x3 with corners, edges and interior, maximum tolerance.
        drain_results(1'b1);
        write_reg(ADDR_SIZE, 32'd3);
        write_reg(ADDR_TOL, 32'h0000_FFFF);
        phase_count++;
        send_list('{16'hFFFF, 16'hFFFF, 16'h0000,
                    16'hFFFF, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000, 16'h0001,
                    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000});

        // Random phases over small sizes and a spread of tolerances.
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                size_value = $urandom_range(0, 1);
            else if (pick == 1)
                size_value = $urandom_range(11, 24);
            else
                size_value = $urandom_range(2, 10);
            case ($urandom_range(0, 5))
                0:       tol_value = 0;
                1:       tol_value = 65535;
                2:       tol_value = $urandom_range(0, 65535);
                default: tol_value = $urandom_range(0, 1500);
            endcase
            keep  = (random_items > 0) && ($urandom_range(0, 3) == 0);
            n     = keep ? tracker.dim() : effective_dim(size_value);
            items = (n <= 10) ? n * n * $urandom_range(1, 2) + $urandom_range(0, n + 1)
                              : 2 * n + $urandom_range(1, n);
            if (items > RANDOM_ITEMS - random_items)
                items = RANDOM_ITEMS - random_items;
            run_phase(size_value, tol_value, items, pattern_t'($urandom_range(0, 2)),
                      keep, phase_count == 2);
            random_items += items;
        end

        // Closing phase without back-pressure or source gaps.
        quiet = 1'b1;
        run_phase(4, $urandom_range(100, 4000), 53, PAT_SMOOTH, 1'b0, 1'b0);

        drain_results(1'b1);
        if (tracker.outstanding() != 0)
            tracker.note_failure($sformatf("%0d results never arrived",
                                           tracker.outstanding()));
        $display("Run covered %0d samples in %0d phases, sizes 2 to 24, %0d results checked.",
                 tracker.samples, phase_count, tracker.checked);
        $display("%0d matrices completed, %0d of them flagged converged; %0d mismatches.",
                 tracker.matrices, tracker.converged_seen, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/enbf_pkg.sv
rtl/enbf_line_buf.sv
rtl/edge_normalized_box_filter_3x3_core.sv
test/testbench.sv
